>>> rtl/sat_pkg.sv
// sat_pkg: shared constants, state encoding and control structs of the
// section address translator. No dependencies.
`timescale 1ns / 1ps

package sat_pkg;

   // default number of section slots
   localparam int SECTION_SLOTS_DEF = 16;

   // field widths fixed by the item format
   localparam int WORD_W   = 32;
   localparam int SLOT_W   = 4;
   localparam int CFG_W    = 5;

   // action codes
   localparam logic ACT_WRITE     = 1'b0;
   localparam logic ACT_TRANSLATE = 1'b1;

   // controller states, one-hot
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic write_entry;
      logic start;
      logic issue;
      logic check;
      logic load_rsp;
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic skip;
      logic hit;
      logic issued_all;
      logic rsp_free;
   } status_type;

endpackage

>>> rtl/sat_if.sv
// sat_if: valid/ready channel interfaces for request, response and
// configuration items. Depends on sat_pkg for field widths.
`timescale 1ns / 1ps

interface sat_req_if;
   logic                      valid;
   logic                      ready;
   logic                      action;
   logic [sat_pkg::SLOT_W-1:0] entry_index;
   logic [sat_pkg::WORD_W-1:0] section_start;
   logic [sat_pkg::WORD_W-1:0] section_length;
   logic [sat_pkg::WORD_W-1:0] section_file_pointer;
   logic [sat_pkg::WORD_W-1:0] lookup_address;

   modport source (output valid, action, entry_index, section_start, section_length,
                   section_file_pointer, lookup_address, input ready);
   modport sink (input valid, action, entry_index, section_start, section_length,
                 section_file_pointer, lookup_address, output ready);
endinterface

interface sat_rsp_if;
   logic                      valid;
   logic                      ready;
   logic                      found;
   logic [sat_pkg::WORD_W-1:0] file_offset;
   logic [sat_pkg::SLOT_W-1:0] hit_index;

   modport source (output valid, found, file_offset, hit_index, input ready);
   modport sink (input valid, found, file_offset, hit_index, output ready);
endinterface

interface sat_csr_if;
   logic                     valid;
   logic                     ready;
   logic [sat_pkg::CFG_W-1:0] sections_in_use;

   modport source (output valid, sections_in_use, input ready);
   modport sink (input valid, sections_in_use, output ready);
endinterface

>>> rtl/sat_ram.sv
// sat_ram: generic single write port, single read port RAM with
// registered read data. No dependencies.
`timescale 1ns / 1ps

module sat_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/sat_datapath.sv
// sat_datapath: section table, scan counter, range compare, result and
// output registers. Depends on sat_pkg and sat_ram.
`timescale 1ns / 1ps

module sat_datapath #(
   parameter int SECTION_SLOTS = sat_pkg::SECTION_SLOTS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  sat_pkg::cmd_type            cmd,
   output sat_pkg::status_type         status,
   input  logic [sat_pkg::SLOT_W-1:0]  req_entry_index,
   input  logic [sat_pkg::WORD_W-1:0]  req_section_start,
   input  logic [sat_pkg::WORD_W-1:0]  req_section_length,
   input  logic [sat_pkg::WORD_W-1:0]  req_section_file_pointer,
   input  logic [sat_pkg::WORD_W-1:0]  req_lookup_address,
   input  logic                        csr_write,
   input  logic [sat_pkg::CFG_W-1:0]   csr_sections_in_use,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_found,
   output logic [sat_pkg::WORD_W-1:0]  rsp_file_offset,
   output logic [sat_pkg::SLOT_W-1:0]  rsp_hit_index
);

   import sat_pkg::*;

   localparam int AW     = (SECTION_SLOTS > 1) ? $clog2(SECTION_SLOTS) : 1;
   localparam int CW     = (AW + 1 > CFG_W) ? AW + 1 : CFG_W;
   localparam int ROW_W  = 3 * WORD_W;

   logic [CFG_W-1:0]   cfg_ff;
   logic [CW-1:0]      limit;
   logic [CW-1:0]      cfg_ext;
   logic [CW-1:0]      widx;
   logic               ram_we;
   logic [ROW_W-1:0]   ram_rdata;
   logic [WORD_W-1:0]  ent_start;
   logic [WORD_W-1:0]  ent_length;
   logic [WORD_W-1:0]  ent_pointer;
   logic [WORD_W:0]    ent_end;
   logic               match;
   logic [WORD_W-1:0]  offset;

   logic [WORD_W-1:0]  addr_ff, addr_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic               pv_ff, pv_in;
   logic [CW-1:0]      pidx_ff, pidx_in;
   logic               found_ff, found_in;
   logic [WORD_W-1:0]  off_ff, off_in;
   logic [SLOT_W-1:0]  hidx_ff, hidx_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_found_ff, rsp_found_in;
   logic [WORD_W-1:0]  rsp_off_ff, rsp_off_in;
   logic [SLOT_W-1:0]  rsp_idx_ff, rsp_idx_in;

   // configuration register and saturated scan limit
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_write) begin
         cfg_ff <= csr_sections_in_use;
      end
   end

   assign cfg_ext = CW'(cfg_ff);
   assign limit   = (cfg_ext > CW'(SECTION_SLOTS)) ? CW'(SECTION_SLOTS) : cfg_ext;

   // table write, out-of-range slots dropped
   assign widx   = CW'(req_entry_index);
   assign ram_we = cmd.write_entry && (widx < CW'(SECTION_SLOTS));

   sat_ram #(
      .WIDTH (ROW_W),
      .DEPTH (SECTION_SLOTS),
      .AW    (AW)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (widx[AW-1:0]),
      .wdata ({req_section_start, req_section_length, req_section_file_pointer}),
      .re    (cmd.issue),
      .raddr (cnt_ff[AW-1:0]),
      .rdata (ram_rdata)
   );

   // range compare on the entry read last cycle, end kept at 33 bits
   assign {ent_start, ent_length, ent_pointer} = ram_rdata;
   assign ent_end = {1'b0, ent_start} + {1'b0, ent_length};
   assign match   = (addr_ff >= ent_start) && ({1'b0, addr_ff} < ent_end);
   assign offset  = (addr_ff - ent_start) + ent_pointer;

   // scan and result registers
   always_comb begin
      addr_in  = addr_ff;
      cnt_in   = cnt_ff;
      pidx_in  = cnt_ff;
      pv_in    = cmd.issue;
      found_in = found_ff;
      off_in   = off_ff;
      hidx_in  = hidx_ff;
      if (cmd.start) begin
         addr_in  = req_lookup_address;
         cnt_in   = '0;
         found_in = 1'b0;
         off_in   = '0;
         hidx_in  = '0;
      end else if (cmd.issue) begin
         cnt_in = cnt_ff + CW'(1);
      end
      if (cmd.check && pv_ff && match) begin
         found_in = 1'b1;
         off_in   = offset;
         hidx_in  = pidx_ff[SLOT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
      end else begin
         pv_ff <= pv_in;
      end
      addr_ff  <= addr_in;
      cnt_ff   <= cnt_in;
      pidx_ff  <= pidx_in;
      found_ff <= found_in;
      off_ff   <= off_in;
      hidx_ff  <= hidx_in;
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_found_in = rsp_found_ff;
      rsp_off_in   = rsp_off_ff;
      rsp_idx_in   = rsp_idx_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_found_in = found_ff;
         rsp_off_in   = off_ff;
         rsp_idx_in   = hidx_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_found_ff <= rsp_found_in;
      rsp_off_ff   <= rsp_off_in;
      rsp_idx_ff   <= rsp_idx_in;
   end

   // status to controller
   assign status.skip       = (req_lookup_address == '0) || (limit == '0);
   assign status.hit        = pv_ff && match;
   assign status.issued_all = (cnt_ff == limit);
   assign status.rsp_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_file_offset = rsp_off_ff;
   assign rsp_hit_index   = rsp_idx_ff;

endmodule

>>> rtl/sat_controller.sv
// sat_controller: one-hot state machine that sequences table writes,
// the entry scan and the hand-off to the output register. Depends on sat_pkg.
`timescale 1ns / 1ps

module sat_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_action,
   output logic                req_ready,
   output sat_pkg::cmd_type    cmd,
   input  sat_pkg::status_type status
);

   import sat_pkg::*;

   state_type state_ff, state_in;
   logic      accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // next state and commands
   always_comb begin
      state_in        = state_ff;
      cmd             = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_action == ACT_WRITE) begin
                  cmd.write_entry = 1'b1;
               end else begin
                  cmd.start = 1'b1;
                  state_in  = status.skip ? ST_DONE : ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            cmd.check = 1'b1;
            cmd.issue = !status.issued_all && !status.hit;
            // last entry checked once everything is issued
            if (status.hit || status.issued_all) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> rtl/section_address_translator.sv
// Section address translator: a table of SECTION_SLOTS section entries
// (start, length, file pointer) in one RAM, scanned in index order; a translate
// item returns the file offset of the first entry whose range holds its address.
// A translate item with a zero address or no sections in use skips the scan
// and returns a miss; otherwise the scan reads one entry per cycle from the
// table RAM until an entry hits or all of the sections in use have been read.
// A finished result waits in an output register; the next item is accepted
// while it waits. Depends on sat_pkg, sat_if, sat_ram, sat_controller and
// sat_datapath.
`timescale 1ns / 1ps

module section_address_translator #(
   parameter int SECTION_SLOTS = sat_pkg::SECTION_SLOTS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   sat_req_if.sink    req_if,
   sat_rsp_if.source  rsp_if,
   sat_csr_if.sink    csr_if
);

   import sat_pkg::*;

   cmd_type    cmd;
   status_type status;

   // configuration writes are always taken
   assign csr_if.ready = 1'b1;

   sat_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_if.valid),
      .req_action (req_if.action),
      .req_ready  (req_if.ready),
      .cmd        (cmd),
      .status     (status)
   );

   sat_datapath #(
      .SECTION_SLOTS (SECTION_SLOTS)
   ) u_dp (
      .clock                    (clock),
      .reset                    (reset),
      .cmd                      (cmd),
      .status                   (status),
      .req_entry_index          (req_if.entry_index),
      .req_section_start        (req_if.section_start),
      .req_section_length       (req_if.section_length),
      .req_section_file_pointer (req_if.section_file_pointer),
      .req_lookup_address       (req_if.lookup_address),
      .csr_write                (csr_if.valid),
      .csr_sections_in_use      (csr_if.sections_in_use),
      .rsp_valid                (rsp_if.valid),
      .rsp_ready                (rsp_if.ready),
      .rsp_found                (rsp_if.found),
      .rsp_file_offset          (rsp_if.file_offset),
      .rsp_hit_index            (rsp_if.hit_index)
   );

endmodule

>>> rtl/sat_checker.sv
// sat_checker: port-level assertions for the section address translator,
// bound to the top level. Depends on sat_pkg for field widths.
`timescale 1ns / 1ps

module sat_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       req_action,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic                       rsp_found,
   input logic [sat_pkg::WORD_W-1:0] rsp_file_offset,
   input logic [sat_pkg::SLOT_W-1:0] rsp_hit_index
);

   import sat_pkg::*;

   // no result right after reset
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a miss carries zero offset and index
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> (rsp_file_offset == '0) && (rsp_hit_index == '0))
      else $error("miss result with nonzero fields");

   // a translate item leaves the block busy, not ready, in the next cycle
   a_translate_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_action == ACT_TRANSLATE) |=> !req_ready)
      else $error("item accepted during a scan");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found)
         && $stable(rsp_file_offset) && $stable(rsp_hit_index))
      else $error("stalled result changed");

endmodule

bind section_address_translator sat_checker u_sat_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_if.valid),
   .req_ready       (req_if.ready),
   .req_action      (req_if.action),
   .rsp_valid       (rsp_if.valid),
   .rsp_ready       (rsp_if.ready),
   .rsp_found       (rsp_if.found),
   .rsp_file_offset (rsp_if.file_offset),
   .rsp_hit_index   (rsp_if.hit_index)
);
